>>> rtl/stepper_tone_generator_assert.svh
// Assertion macros for the stepper tone generator.
// Included by the modules that check their own sequencing and datapath.
`ifndef STEPPER_TONE_GENERATOR_ASSERT_SVH
`define STEPPER_TONE_GENERATOR_ASSERT_SVH

// Checks an implication or condition at every clock edge outside reset.
`define STG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("stepper tone generator check failed");

// Checks that a condition in one cycle is followed by another in the next.
`define STG_ASSERT_NEXT(lbl, cause, effect) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error("stepper tone generator sequence check failed");

`endif

>>> rtl/stg_pkg.sv
// Shared types, constants and the control program of the stepper tone generator.
// Used by the sequencer, the datapath and the top level.
package stg_pkg;

  localparam int CHANNELS    = 8;
  localparam int PERIOD_BITS = 16;
  localparam int CHAN_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_BITS    = 8;
  localparam int PINS        = 8;

  localparam logic [POS_BITS-1:0] TURN_POS_RESET = 8'd158;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [2:0]  channel;
    logic [15:0] half_period;
  } in_beat_t;

  typedef struct packed {
    logic [PINS-1:0] step_pins;
    logic [PINS-1:0] direction_pins;
    logic [PINS-1:0] select_n;
  } out_beat_t;

  typedef enum logic [2:0] {
    S_FETCH,
    S_DECODE,
    S_SET,
    S_TICK,
    S_EMIT
  } step_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_IN_VALID,
    C_CMD_SET,
    C_LAST_CHAN,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    logic  accept;
    logic  write_period;
    logic  tick;
    logic  emit;
    cond_t cond;
    step_t jump_true;
    step_t jump_false;
  } ucode_t;

  typedef struct packed {
    logic                 load_item;
    logic                 write_period;
    logic                 tick;
    logic                 emit;
    logic [CHAN_BITS-1:0] chan;
  } dp_ctrl_t;

  typedef struct packed {
    logic cmd_set;
    logic out_free;
  } dp_stat_t;

  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    w = '{accept: 1'b0, write_period: 1'b0, tick: 1'b0, emit: 1'b0,
          cond: C_ALWAYS, jump_true: S_FETCH, jump_false: S_FETCH};
    unique case (s)
      S_FETCH: begin
        w.accept     = 1'b1;
        w.cond       = C_IN_VALID;
        w.jump_true  = S_DECODE;
        w.jump_false = S_FETCH;
      end
      S_DECODE: begin
        w.cond       = C_CMD_SET;
        w.jump_true  = S_SET;
        w.jump_false = S_TICK;
      end
      S_SET: begin
        w.write_period = 1'b1;
        w.cond         = C_ALWAYS;
        w.jump_true    = S_EMIT;
        w.jump_false   = S_EMIT;
      end
      S_TICK: begin
        w.tick       = 1'b1;
        w.cond       = C_LAST_CHAN;
        w.jump_true  = S_EMIT;
        w.jump_false = S_TICK;
      end
      S_EMIT: begin
        w.emit       = 1'b1;
        w.cond       = C_OUT_FREE;
        w.jump_true  = S_FETCH;
        w.jump_false = S_EMIT;
      end
      default: begin
        w.cond       = C_ALWAYS;
        w.jump_true  = S_FETCH;
        w.jump_false = S_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/stepper_tone_generator.sv
// Eight-channel stepper tone generator. A set beat stores one channel's half-period
// (zero silences it and raises its select_n bit); it passes through the fetch,
// decode, write and emit steps, and its result is registered at the emit step. A tick
// beat visits the channels one per cycle through a single shared count-and-step unit;
// it passes through fetch, decode, the tick sweep over all channels and emit. Every beat
// yields one result with all pins. The result register lets the next beat be taken
// while a result waits; the emit step stalls only while an earlier result is still
// held. The turn-back head position is written through cfg_we/cfg_data.
// Depends on stg_pkg, stg_sequencer and stg_datapath.
module stepper_tone_generator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  stg_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output stg_pkg::out_beat_t out_data,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data
);
  import stg_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  stg_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  stg_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .stat      (stat)
  );

endmodule

>>> rtl/stg_sequencer.sv
// Microcoded sequencer: step counter, control store lookup and channel counter.
// Depends on stg_pkg and the assertion macro header.
`include "stepper_tone_generator_assert.svh"

module stg_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  stg_pkg::dp_stat_t stat,
  output logic             in_ready,
  output stg_pkg::dp_ctrl_t ctrl
);
  import stg_pkg::*;

  localparam logic [CHAN_BITS-1:0] LAST_CHAN = CHAN_BITS'(CHANNELS - 1);

  step_t                step;
  step_t                step_next;
  logic [CHAN_BITS-1:0] chan;
  logic [CHAN_BITS-1:0] chan_next;
  ucode_t               uw;
  logic                 cond_true;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_FETCH;
      chan <= '0;
    end else begin
      step <= step_next;
      chan <= chan_next;
    end
  end

  always_comb begin
    uw = ucode_rom(step);
    unique case (uw.cond)
      C_ALWAYS:    cond_true = 1'b1;
      C_IN_VALID:  cond_true = in_valid;
      C_CMD_SET:   cond_true = stat.cmd_set;
      C_LAST_CHAN: cond_true = (chan == LAST_CHAN);
      C_OUT_FREE:  cond_true = stat.out_free;
      default:     cond_true = 1'b1;
    endcase
    step_next = cond_true ? uw.jump_true : uw.jump_false;
    chan_next = chan;
    if (uw.tick) begin
      chan_next = (chan == LAST_CHAN) ? '0 : chan + 1'b1;
    end
    in_ready          = uw.accept;
    ctrl.load_item    = uw.accept & in_valid;
    ctrl.write_period = uw.write_period;
    ctrl.tick         = uw.tick;
    ctrl.emit         = uw.emit;
    ctrl.chan         = chan;
  end

  `STG_ASSERT_NEXT(a_accept_decodes, in_valid && in_ready, step == S_DECODE)
  `STG_ASSERT(a_chan_idle_zero, (step != S_TICK) |-> (chan == '0))
  `STG_ASSERT_NEXT(a_sweep_ends, (step == S_TICK) && (chan == LAST_CHAN), step == S_EMIT)

endmodule

>>> rtl/stg_datapath.sv
// Datapath: item register, per-channel period, count, head and pin state, result register.
// Depends on stg_pkg and the assertion macro header; driven by stg_sequencer.
`include "stepper_tone_generator_assert.svh"

module stg_datapath (
  input  logic              clk,
  input  logic              rst,
  input  stg_pkg::dp_ctrl_t ctrl,
  input  stg_pkg::in_beat_t in_data,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_data,
  input  logic              out_ready,
  output logic              out_valid,
  output stg_pkg::out_beat_t out_data,
  output stg_pkg::dp_stat_t stat
);
  import stg_pkg::*;

  in_beat_t               item;
  logic [POS_BITS-1:0]    turn_pos;
  logic [PERIOD_BITS-1:0] period_store [CHANNELS];
  logic [PERIOD_BITS-1:0] tick_count [CHANNELS];
  logic [POS_BITS-1:0]    head_position [CHANNELS];
  logic [CHANNELS-1:0]    moving_backward;
  logic [CHANNELS-1:0]    next_step_level;
  logic [CHANNELS-1:0]    step_level_out;

  logic [CHAN_BITS-1:0]   set_idx;
  logic                   set_ok;
  logic [PERIOD_BITS-1:0] set_value;
  logic [PERIOD_BITS-1:0] cur_period;
  logic [PERIOD_BITS-1:0] count_inc;
  logic                   active;
  logic                   hit;
  logic [POS_BITS-1:0]    cur_pos;
  logic                   back_new;
  logic [POS_BITS-1:0]    pos_new;
  out_beat_t              pins;

  always_comb begin
    set_idx    = CHAN_BITS'(item.channel);
    set_ok     = (32'(item.channel) < CHANNELS);
    set_value  = PERIOD_BITS'(item.half_period);
    cur_period = period_store[ctrl.chan];
    count_inc  = tick_count[ctrl.chan] + 1'b1;
    active     = (cur_period != '0);
    hit        = (count_inc >= cur_period);
    cur_pos    = head_position[ctrl.chan];
    if (cur_pos >= turn_pos) begin
      back_new = 1'b1;
    end else if (cur_pos == '0) begin
      back_new = 1'b0;
    end else begin
      back_new = moving_backward[ctrl.chan];
    end
    pos_new       = back_new ? cur_pos - 1'b1 : cur_pos + 1'b1;
    stat.cmd_set  = (item.cmd == CMD_SET);
    stat.out_free = !out_valid || out_ready;
  end

  always_comb begin
    pins.step_pins      = '0;
    pins.direction_pins = '0;
    pins.select_n       = '1;
    for (int i = 0; i < PINS; i++) begin
      if (i < CHANNELS) begin
        pins.step_pins[i]      = step_level_out[CHAN_BITS'(i)];
        pins.direction_pins[i] = moving_backward[CHAN_BITS'(i)];
        pins.select_n[i]       = (period_store[CHAN_BITS'(i)] == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_item) begin
      item <= in_data;
    end
    if (ctrl.emit && stat.out_free) begin
      out_data <= pins;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      turn_pos        <= TURN_POS_RESET;
      moving_backward <= '0;
      next_step_level <= '0;
      step_level_out  <= '0;
      out_valid       <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        period_store[i]  <= '0;
        tick_count[i]    <= '0;
        head_position[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        turn_pos <= cfg_data;
      end
      if (ctrl.write_period && set_ok) begin
        period_store[set_idx] <= set_value;
      end
      if (ctrl.tick && active) begin
        if (hit) begin
          tick_count[ctrl.chan]      <= '0;
          head_position[ctrl.chan]   <= pos_new;
          moving_backward[ctrl.chan] <= back_new;
          step_level_out[ctrl.chan]  <= next_step_level[ctrl.chan];
          next_step_level[ctrl.chan] <= ~next_step_level[ctrl.chan];
        end else begin
          tick_count[ctrl.chan] <= count_inc;
        end
      end
      if (ctrl.emit && stat.out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `STG_ASSERT_NEXT(a_emit_loads, ctrl.emit && stat.out_free, out_valid)
  `STG_ASSERT_NEXT(a_taken_clears, out_valid && out_ready && !ctrl.emit, !out_valid)
  `STG_ASSERT_NEXT(a_period_written, ctrl.write_period && set_ok, period_store[$past(set_idx)] == $past(set_value))

endmodule

>>> test/stepper_tone_generator_tb.sv
// Self-checking testbench for stepper_tone_generator: random valid/ready traffic and a
// bit-accurate model of the eight channels' counts, heads, directions and step pins.
// Depends on stg_pkg and the stepper_tone_generator RTL.
module stepper_tone_generator_tb;
  import stg_pkg::*;

  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_data = 8'd0;

  stepper_tone_generator dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  logic [15:0] period_tbl [CHANNELS];
  logic [15:0] count_tbl [CHANNELS];
  logic [7:0] head_pos [CHANNELS];
  logic heading_back [CHANNELS];
  logic level_next [CHANNELS];
  logic level_out [CHANNELS];
  logic [7:0] limit_pos = TURN_POS_RESET;

  in_beat_t beats_to_send [$];
  out_beat_t pins_due [$];
  int issued = 0;
  int taken = 0;
  int mismatches = 0;
  int cycles = 0;
  bit calm = 1'b0;

  initial begin
    for (int c = 0; c < CHANNELS; c++) begin
      period_tbl[c] = '0;
      count_tbl[c] = '0;
      head_pos[c] = '0;
      heading_back[c] = 1'b0;
      level_next[c] = 1'b0;
      level_out[c] = 1'b0;
    end
  end

  function automatic out_beat_t advance_pins(input in_beat_t b);
    out_beat_t r;
    if (b.cmd == CMD_SET) begin
      period_tbl[b.channel] = b.half_period;
    end else begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (period_tbl[c] != 16'd0) begin
          count_tbl[c] = count_tbl[c] + 16'd1;
          if (count_tbl[c] >= period_tbl[c]) begin
            if (head_pos[c] >= limit_pos) begin
              heading_back[c] = 1'b1;
            end else if (head_pos[c] == 8'd0) begin
              heading_back[c] = 1'b0;
            end
            head_pos[c] = heading_back[c] ? head_pos[c] - 8'd1 : head_pos[c] + 8'd1;
            level_out[c] = level_next[c];
            level_next[c] = ~level_next[c];
            count_tbl[c] = '0;
          end
        end
      end
    end
    r.step_pins = '0;
    r.direction_pins = '0;
    r.select_n = '1;
    for (int c = 0; c < CHANNELS; c++) begin
      r.step_pins[c] = level_out[c];
      r.direction_pins[c] = heading_back[c];
      r.select_n[c] = (period_tbl[c] == 16'd0);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatches < 40) begin
      $display("Mismatch on %s at cycle %0d: got %h, expected %h", what, cycles, got, want);
    end
    mismatches++;
  endtask

  // Input side.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pins_due.push_back(advance_pins(in_data));
        taken++;
      end
      if (!in_valid || in_ready) begin
        if (beats_to_send.size() != 0 && (calm || $urandom_range(99) >= 14)) begin
          in_valid <= 1'b1;
          in_data <= beats_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pins_due.size() == 0) begin
          report_mismatch("unexpected beat", out_data.step_pins, 8'h00);
        end else begin
          out_beat_t want;
          want = pins_due.pop_front();
          if (out_data.step_pins !== want.step_pins) begin
            report_mismatch("step_pins", out_data.step_pins, want.step_pins);
          end
          if (out_data.direction_pins !== want.direction_pins) begin
            report_mismatch("direction_pins", out_data.direction_pins, want.direction_pins);
          end
          if (out_data.select_n !== want.select_n) begin
            report_mismatch("select_n", out_data.select_n, want.select_n);
          end
        end
      end
      out_ready <= calm || ($urandom_range(99) >= 14);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic queue_beat(input logic cmd, input logic [2:0] chan, input logic [15:0] half);
    in_beat_t b;
    b.cmd = cmd;
    b.channel = chan;
    b.half_period = half;
    beats_to_send.push_back(b);
    issued++;
  endtask

  task automatic queue_random_beat();
    int pick;
    logic [15:0] half;
    if ($urandom_range(99) < 65) begin
      queue_beat(CMD_TICK, 3'($urandom), 16'($urandom));
    end else begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        half = 16'd0;
      end else if (pick < 70) begin
        half = 16'($urandom_range(4, 1));
      end else if (pick < 85) begin
        half = 16'($urandom_range(40, 5));
      end else begin
        half = 16'($urandom);
      end
      queue_beat(CMD_SET, 3'($urandom), half);
    end
  endtask

  task automatic drain();
    while (taken != issued || pins_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (16) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    limit_pos = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [7:0] limits [7];
    limits = '{TURN_POS_RESET, 8'd1, 8'd255, 8'd0, 8'd3, 8'($urandom_range(254, 1)),
               8'd40};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    queue_beat(CMD_TICK, 3'd7, 16'hFFFF);
    queue_beat(CMD_SET, 3'd0, 16'd1);
    queue_beat(CMD_SET, 3'd7, 16'hFFFF);
    queue_beat(CMD_SET, 3'd5, 16'h5555);
    queue_beat(CMD_SET, 3'd6, 16'hAAAA);
    queue_beat(CMD_SET, 3'd2, 16'd5);
    repeat (4) queue_beat(CMD_TICK, 3'd0, 16'd0);
    queue_beat(CMD_SET, 3'd2, 16'd2);
    queue_beat(CMD_TICK, 3'd0, 16'd0);
    queue_beat(CMD_SET, 3'd5, 16'd0);
    queue_beat(CMD_SET, 3'd6, 16'd0);
    queue_beat(CMD_SET, 3'd1, 16'd3);
    queue_beat(CMD_SET, 3'd3, 16'd1);
    queue_beat(CMD_SET, 3'd4, 16'd2);
    repeat (5) queue_beat(CMD_TICK, 3'd5, 16'h1234);
    queue_beat(CMD_SET, 3'd7, 16'd0);
    drain();

    for (int p = 0; p < 7; p++) begin
      if (p != 0) begin
        write_limit(limits[p]);
      end
      calm = (p == 2);
      repeat (190) queue_random_beat();
      drain();
    end

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
